// ----- sv/nsq_pkg.sv -----
// Shared types, constants and helpers of the nine-slice quad builder.
package nsq_pkg;

  localparam int NUM_SLICES = 3;
  localparam int NUM_PIECES = NUM_SLICES * NUM_SLICES;
  localparam int DIV_STEPS  = 27;
  localparam logic [16:0] Q16_ONE = 17'd65536;

  typedef enum logic [2:0] {
    CFG_SLICE_TOP    = 3'd0,
    CFG_SLICE_RIGHT  = 3'd1,
    CFG_SLICE_BOTTOM = 3'd2,
    CFG_SLICE_LEFT   = 3'd3,
    CFG_FILL_CENTER  = 3'd4,
    CFG_TEX_WIDTH    = 3'd5,
    CFG_TEX_HEIGHT   = 3'd6
  } cfg_reg_e;

  // Item data that rides alongside the dividers.
  typedef struct packed {
    logic [23:0] vx;
    logic [23:0] vy;
    logic [19:0] vw;
    logic [19:0] vh;
    logic [16:0] tu;
    logic [16:0] tv;
    logic [16:0] su;
    logic [16:0] sv;
    logic        inv;
    logic        scx;
    logic        scy;
  } side_t;

  // One item ready for emission: per column and per row quad data.
  typedef struct packed {
    logic [NUM_SLICES-1:0][24:0] px;
    logic [NUM_SLICES-1:0][19:0] pw;
    logic [NUM_SLICES-1:0][24:0] py;
    logic [NUM_SLICES-1:0][19:0] ph;
    logic [NUM_SLICES-1:0][16:0] pu;
    logic [NUM_SLICES-1:0][16:0] psu;
    logic [NUM_SLICES-1:0][16:0] pv;
    logic [NUM_SLICES-1:0][16:0] psv;
    logic [NUM_PIECES-1:0]       mask;
    logic                        refused;
  } item_t;

  function automatic logic [16:0] sat_q16(input logic signed [28:0] v);
    logic [16:0] r;
    if (v < 29'sd0) r = 17'd0;
    else if (v > 29'sd65536) r = Q16_ONE;
    else r = v[16:0];
    return r;
  endfunction

  function automatic logic [16:0] sat_span(input logic [16:0] hi, input logic [16:0] lo);
    logic signed [17:0] d;
    logic [16:0] r;
    d = $signed({1'b0, hi}) - $signed({1'b0, lo});
    if (d < 18'sd0) r = 17'd0;
    else r = d[16:0];
    return r;
  endfunction

endpackage

// ----- sv/nine_slice_quad_builder.sv -----
// Top level of the nine-slice quad builder: config, pipeline and quad emitter.
//
// Each transfer on the input channel describes a view rectangle, a normalized
// texture rectangle and a fragment size; the block answers with one to nine
// quad transfers, top row first and left to right, the final one flagged by
// last. Invalid margins (negative, or meeting the fragment size) or a layout
// with no non-empty piece give a single transfer with refused and last set and
// all other fields zero. A new item is taken every cycle while the emitter
// keeps up, so throughput is set by the output channel at one quad per cycle
// while out_ready is high. Latency from input transfer to first quad is set
// mostly by the 27-stage pipelined dividers that scale the margins to the view
// and to texture space (one quotient bit per stage). Write the configuration
// registers only while the block is idle.
module nine_slice_quad_builder
  import nsq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input items
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] view_x,
  input  logic [23:0] view_y,
  input  logic [19:0] view_width,
  input  logic [19:0] view_height,
  input  logic [16:0] tex_u,
  input  logic [16:0] tex_v,
  input  logic [16:0] tex_span_u,
  input  logic [16:0] tex_span_v,
  input  logic [19:0] fragment_width,
  input  logic [19:0] fragment_height,
  // result items
  output logic        out_valid,
  input  logic        out_ready,
  output logic [24:0] piece_x,
  output logic [24:0] piece_y,
  output logic [19:0] piece_width,
  output logic [19:0] piece_height,
  output logic [16:0] piece_u,
  output logic [16:0] piece_v,
  output logic [16:0] piece_span_u,
  output logic [16:0] piece_span_v,
  output logic        last,
  output logic        refused
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [15:0] slice_top, slice_right, slice_bottom, slice_left;
  logic        fill_center;
  logic [14:0] tex_width, tex_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slice_top    <= '0;
      slice_right  <= '0;
      slice_bottom <= '0;
      slice_left   <= '0;
      fill_center  <= 1'b1;
      tex_width    <= 15'd1;
      tex_height   <= 15'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_SLICE_TOP:    slice_top    <= cfg_data;
        CFG_SLICE_RIGHT:  slice_right  <= cfg_data;
        CFG_SLICE_BOTTOM: slice_bottom <= cfg_data;
        CFG_SLICE_LEFT:   slice_left   <= cfg_data;
        CFG_FILL_CENTER:  fill_center  <= cfg_data[0];
        CFG_TEX_WIDTH:    tex_width    <= cfg_data[14:0];
        CFG_TEX_HEIGHT:   tex_height   <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // A zero texture size divides as one.
  logic [14:0] tw_eff, th_eff;
  assign tw_eff = (tex_width  == 15'd0) ? 15'd1 : tex_width;
  assign th_eff = (tex_height == 15'd0) ? 15'd1 : tex_height;

  // ---------------------------------------------------------------------------
  // Pipeline control: one global advance, valid bits travel with the data
  // ---------------------------------------------------------------------------
  logic en;
  logic cur_take;
  logic a_valid, p1_valid, p2_valid;
  logic [DIV_STEPS-1:0] dv;

  assign en       = !p2_valid || cur_take;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      dv       <= '0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
    end else if (en) begin
      a_valid  <= in_valid;
      dv       <= {dv[DIV_STEPS-2:0], a_valid};
      p1_valid <= dv[DIV_STEPS-1];
      p2_valid <= p1_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage A: refusal check, scaling decision, margin times view size
  // ---------------------------------------------------------------------------
  logic signed [16:0] sum_lr, sum_tb;
  logic               neg_any, inv_n, scx_n, scy_n;

  always_comb begin
    sum_lr  = $signed({slice_left[15], slice_left}) + $signed({slice_right[15], slice_right});
    sum_tb  = $signed({slice_top[15], slice_top}) + $signed({slice_bottom[15], slice_bottom});
    neg_any = slice_top[15] | slice_right[15] | slice_bottom[15] | slice_left[15];
    inv_n   = neg_any
           || ($signed({{4{sum_lr[16]}}, sum_lr}) >= $signed({1'b0, fragment_width}))
           || ($signed({{4{sum_tb[16]}}, sum_tb}) >= $signed({1'b0, fragment_height}));
    scx_n   = $signed({{4{sum_lr[16]}}, sum_lr}) > $signed({1'b0, view_width});
    scy_n   = $signed({{4{sum_tb[16]}}, sum_tb}) > $signed({1'b0, view_height});
  end

  side_t       a_side;
  logic [34:0] a_prodx, a_prody;
  logic [15:0] a_denx, a_deny;

  always_ff @(posedge clk) begin
    if (en) begin
      a_side.vx  <= view_x;
      a_side.vy  <= view_y;
      a_side.vw  <= view_width;
      a_side.vh  <= view_height;
      a_side.tu  <= tex_u;
      a_side.tv  <= tex_v;
      a_side.su  <= tex_span_u;
      a_side.sv  <= tex_span_v;
      a_side.inv <= inv_n;
      a_side.scx <= scx_n;
      a_side.scy <= scy_n;
      a_prodx    <= slice_left[14:0] * view_width;
      a_prody    <= slice_top[14:0] * view_height;
      a_denx     <= scx_n ? sum_lr[15:0] : 16'd1;
      a_deny     <= scy_n ? sum_tb[15:0] : 16'd1;
    end
  end

  // ---------------------------------------------------------------------------
  // Dividers and the matching delay line
  // ---------------------------------------------------------------------------
  logic [DIV_STEPS-1:0] qx, qy, qul, qur, qvt, qvb;

  nsq_div #(.NW(35), .DW(16), .QW(DIV_STEPS)) u_div_x (
    .clk(clk), .en(en), .num(a_prodx), .den(a_denx), .quo(qx)
  );
  nsq_div #(.NW(35), .DW(16), .QW(DIV_STEPS)) u_div_y (
    .clk(clk), .en(en), .num(a_prody), .den(a_deny), .quo(qy)
  );
  // Texture margins depend on configuration only, which users must hold while busy (unenforced).
  nsq_div #(.NW(28), .DW(15), .QW(DIV_STEPS)) u_div_ul (
    .clk(clk), .en(en), .num({1'b0, slice_left[14:0], 12'd0}), .den(tw_eff), .quo(qul)
  );
  nsq_div #(.NW(28), .DW(15), .QW(DIV_STEPS)) u_div_ur (
    .clk(clk), .en(en), .num({1'b0, slice_right[14:0], 12'd0}), .den(tw_eff), .quo(qur)
  );
  nsq_div #(.NW(28), .DW(15), .QW(DIV_STEPS)) u_div_vt (
    .clk(clk), .en(en), .num({1'b0, slice_top[14:0], 12'd0}), .den(th_eff), .quo(qvt)
  );
  nsq_div #(.NW(28), .DW(15), .QW(DIV_STEPS)) u_div_vb (
    .clk(clk), .en(en), .num({1'b0, slice_bottom[14:0], 12'd0}), .den(th_eff), .quo(qvb)
  );

  side_t sd [DIV_STEPS];

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= a_side;
      for (int k = 1; k < DIV_STEPS; k++) sd[k] <= sd[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P1: view and texture edges
  // ---------------------------------------------------------------------------
  side_t              s;
  logic [19:0]        lx, tx, ty, by;
  logic signed [25:0] x_n [4];
  logic signed [25:0] y_n [4];
  logic [16:0]        u_n [4];
  logic [16:0]        v_n [4];
  logic signed [28:0] tu_s, tv_s, su_s, sv_s;

  always_comb begin
    s  = sd[DIV_STEPS-1];
    lx = s.scx ? qx[19:0] : {5'd0, slice_left[14:0]};
    tx = s.scx ? (s.vw - lx) : {5'd0, slice_right[14:0]};
    ty = s.scy ? qy[19:0] : {5'd0, slice_top[14:0]};
    by = s.scy ? (s.vh - ty) : {5'd0, slice_bottom[14:0]};

    x_n[0] = $signed({{2{s.vx[23]}}, s.vx});
    x_n[1] = x_n[0] + $signed({6'd0, lx});
    x_n[3] = x_n[0] + $signed({6'd0, s.vw});
    x_n[2] = x_n[3] - $signed({6'd0, tx});

    // y grows up: the bottom margin sits above y0, the top one below y3
    y_n[0] = $signed({{2{s.vy[23]}}, s.vy});
    y_n[1] = y_n[0] + $signed({6'd0, by});
    y_n[3] = y_n[0] + $signed({6'd0, s.vh});
    y_n[2] = y_n[3] - $signed({6'd0, ty});

    tu_s = $signed({12'd0, s.tu});
    tv_s = $signed({12'd0, s.tv});
    su_s = $signed({12'd0, s.su});
    sv_s = $signed({12'd0, s.sv});
    u_n[0] = sat_q16(tu_s);
    u_n[1] = sat_q16(tu_s + $signed({2'd0, qul}));
    u_n[2] = sat_q16(tu_s + su_s - $signed({2'd0, qur}));
    u_n[3] = sat_q16(tu_s + su_s);
    v_n[0] = sat_q16(tv_s);
    v_n[1] = sat_q16(tv_s + $signed({2'd0, qvt}));
    v_n[2] = sat_q16(tv_s + sv_s - $signed({2'd0, qvb}));
    v_n[3] = sat_q16(tv_s + sv_s);
  end

  logic signed [25:0] p1_x [4];
  logic signed [25:0] p1_y [4];
  logic [16:0]        p1_u [4];
  logic [16:0]        p1_v [4];
  logic               p1_inv;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_x   <= x_n;
      p1_y   <= y_n;
      p1_u   <= u_n;
      p1_v   <= v_n;
      p1_inv <= s.inv;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage P2: piece sizes, spans and the mask of non-empty pieces
  // ---------------------------------------------------------------------------
  item_t                  it_n;
  logic [NUM_SLICES-1:0]  col_ok, row_ok;
  logic signed [25:0]     dx, dy;

  always_comb begin
    it_n = '0;
    for (int c = 0; c < NUM_SLICES; c++) begin
      dx           = p1_x[c+1] - p1_x[c];
      col_ok[c]    = p1_x[c+1] > p1_x[c];
      it_n.px[c]   = p1_x[c][24:0];
      it_n.pw[c]   = dx[19:0];
      it_n.pu[c]   = p1_u[c];
      it_n.psu[c]  = sat_span(p1_u[c+1], p1_u[c]);
    end
    // row 0 is the top band, between y3 and y2
    for (int r = 0; r < NUM_SLICES; r++) begin
      dy           = p1_y[3-r] - p1_y[2-r];
      row_ok[r]    = p1_y[3-r] > p1_y[2-r];
      it_n.py[r]   = p1_y[2-r][24:0];
      it_n.ph[r]   = dy[19:0];
      it_n.pv[r]   = p1_v[r];
      it_n.psv[r]  = sat_span(p1_v[r+1], p1_v[r]);
    end
    for (int r = 0; r < NUM_SLICES; r++) begin
      for (int c = 0; c < NUM_SLICES; c++) begin
        it_n.mask[r*NUM_SLICES+c] = !p1_inv && row_ok[r] && col_ok[c];
      end
    end
    // drop the centre piece unless filling is on
    if (!fill_center) it_n.mask[NUM_PIECES/2] = 1'b0;
    it_n.refused = p1_inv || (it_n.mask == '0);
  end

  item_t p2_item;

  always_ff @(posedge clk) begin
    if (en) p2_item <= it_n;
  end

  // ---------------------------------------------------------------------------
  // Emitter: hold one item, hand out its quads one transfer at a time
  // ---------------------------------------------------------------------------
  item_t                  cur;
  logic                   cur_valid;
  logic                   load_out, pick_last;
  logic [NUM_PIECES-1:0]  pick, rest;
  logic [NUM_SLICES-1:0]  col_hot, row_hot;
  logic [24:0]            sel_x, sel_y;
  logic [19:0]            sel_w, sel_h;
  logic [16:0]            sel_u, sel_v, sel_su, sel_sv;

  always_comb begin
    pick      = cur.mask & (~cur.mask + 1'b1);
    rest      = cur.mask & ~pick;
    pick_last = cur.refused || (rest == '0);
    for (int c = 0; c < NUM_SLICES; c++) begin
      col_hot[c] = 1'b0;
      for (int r = 0; r < NUM_SLICES; r++) col_hot[c] = col_hot[c] | pick[r*NUM_SLICES+c];
    end
    for (int r = 0; r < NUM_SLICES; r++) begin
      row_hot[r] = |pick[r*NUM_SLICES +: NUM_SLICES];
    end
    sel_x = '0; sel_w = '0; sel_u = '0; sel_su = '0;
    sel_y = '0; sel_h = '0; sel_v = '0; sel_sv = '0;
    for (int c = 0; c < NUM_SLICES; c++) begin
      if (col_hot[c]) begin
        sel_x  = sel_x  | cur.px[c];
        sel_w  = sel_w  | cur.pw[c];
        sel_u  = sel_u  | cur.pu[c];
        sel_su = sel_su | cur.psu[c];
      end
    end
    for (int r = 0; r < NUM_SLICES; r++) begin
      if (row_hot[r]) begin
        sel_y  = sel_y  | cur.py[r];
        sel_h  = sel_h  | cur.ph[r];
        sel_v  = sel_v  | cur.pv[r];
        sel_sv = sel_sv | cur.psv[r];
      end
    end
    load_out = cur_valid && (!out_valid || out_ready);
    cur_take = !cur_valid || (load_out && pick_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // advance the held item, or take the next one off the pipeline
      if (en && p2_valid) begin
        cur       <= p2_item;
        cur_valid <= 1'b1;
      end else if (load_out) begin
        cur.mask <= rest;
        if (pick_last) cur_valid <= 1'b0;
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      piece_x      <= cur.refused ? '0 : sel_x;
      piece_y      <= cur.refused ? '0 : sel_y;
      piece_width  <= cur.refused ? '0 : sel_w;
      piece_height <= cur.refused ? '0 : sel_h;
      piece_u      <= cur.refused ? '0 : sel_u;
      piece_v      <= cur.refused ? '0 : sel_v;
      piece_span_u <= cur.refused ? '0 : sel_su;
      piece_span_v <= cur.refused ? '0 : sel_sv;
      last         <= pick_last;
      refused      <= cur.refused;
    end
  end

endmodule

// ----- sv/nsq_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
module nsq_div #(
  parameter int NW = 35,
  parameter int DW = 16,
  parameter int QW = 27
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int RW = NW - QW;

  logic [DW-1:0] s_rem [QW];
  logic [QW-1:0] s_nq  [QW];
  logic [DW-1:0] s_den [QW];

  logic [DW-1:0] in_rem [QW];
  logic [QW-1:0] in_nq  [QW];
  logic [DW-1:0] in_den [QW];
  logic [DW-1:0] nx_rem [QW];
  logic [QW-1:0] nx_nq  [QW];

  // Upper dividend bits start as the partial remainder; the quotient fits only while they stay below den.
  assign in_rem[0] = {{(DW-RW){1'b0}}, num[NW-1:QW]};
  assign in_nq[0]  = num[QW-1:0];
  assign in_den[0] = den;

  for (genvar k = 1; k < QW; k++) begin : g_link
    assign in_rem[k] = s_rem[k-1];
    assign in_nq[k]  = s_nq[k-1];
    assign in_den[k] = s_den[k-1];
  end

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;
    assign trial = {in_rem[k], in_nq[k][QW-1]};
    assign diff  = trial - {1'b0, in_den[k]};
    assign ge    = trial >= {1'b0, in_den[k]};
    assign nx_rem[k] = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign nx_nq[k]  = {in_nq[k][QW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QW; k++) begin
        s_rem[k] <= nx_rem[k];
        s_nq[k]  <= nx_nq[k];
        s_den[k] <= in_den[k];
      end
    end
  end

  assign quo = s_nq[QW-1];

endmodule

// ----- dv/nine_slice_quad_builder_tb.sv -----
// Testbench for the nine-slice quad builder: random and directed stimulus, scoreboard check.
`timescale 1ns / 100ps

module tb;
  import nsq_pkg::*;

  // One input transfer: view rectangle, texture rectangle, fragment size.
  typedef struct {
    logic signed [23:0] view_x;
    logic signed [23:0] view_y;
    logic [19:0] view_width;
    logic [19:0] view_height;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic [16:0] tex_span_u;
    logic [16:0] tex_span_v;
    logic [19:0] fragment_width;
    logic [19:0] fragment_height;
  } slice_req_t;

  // One result transfer: a quad or a refusal.
  typedef struct {
    logic signed [24:0] x;
    logic signed [24:0] y;
    logic [19:0] w;
    logic [19:0] h;
    logic [16:0] u;
    logic [16:0] v;
    logic [16:0] su;
    logic [16:0] sv;
    logic        last;
    logic        refused;
  } quad_t;

  // Keeps a private copy of the registers, predicts the quads of each accepted
  // request and compares every returned quad against the oldest prediction.
  class quad_book;
    int signed margin_top, margin_right, margin_bottom, margin_left;
    bit        fill;
    int        tex_w, tex_h;
    quad_t     pending_quads[$];
    int        errors;

    function new();
      margin_top = 0; margin_right = 0; margin_bottom = 0; margin_left = 0;
      fill = 1; tex_w = 1; tex_h = 1; errors = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [15:0] data);
      case (idx)
        CFG_SLICE_TOP:    margin_top    = int'($signed(data));
        CFG_SLICE_RIGHT:  margin_right  = int'($signed(data));
        CFG_SLICE_BOTTOM: margin_bottom = int'($signed(data));
        CFG_SLICE_LEFT:   margin_left   = int'($signed(data));
        CFG_FILL_CENTER:  fill          = data[0];
        CFG_TEX_WIDTH:    tex_w         = int'({17'd0, data[14:0]});
        CFG_TEX_HEIGHT:   tex_h         = int'({17'd0, data[14:0]});
        default: ;
      endcase
    endfunction

    function longint clamp_q16(longint val);
      if (val < 0) return 0;
      if (val > 65536) return 65536;
      return val;
    endfunction

    function void push_refusal();
      quad_t q;
      q = '{default: 0};
      q.last = 1;
      q.refused = 1;
      pending_quads.push_back(q);
    endfunction

    // Predict the quads of one request and queue them.
    function void note_req(slice_req_t r);
      longint vx, vy, vw, vh, lm, rm, tm, bm, dw, dh, lead, trail;
      longint xe[4], ye[4], ue[4], ve[4];
      quad_t  q, found[$];
      vx = longint'(r.view_x);
      vy = longint'(r.view_y);
      vw = r.view_width;
      vh = r.view_height;
      lm = margin_left; rm = margin_right; tm = margin_top; bm = margin_bottom;
      if (tm < 0 || rm < 0 || bm < 0 || lm < 0 ||
          lm + rm >= longint'(r.fragment_width) || tm + bm >= longint'(r.fragment_height)) begin
        push_refusal();
        return;
      end
      // shrink the corners in proportion when the view cannot hold both margins
      lead = lm; trail = rm;
      if (lm + rm > vw) begin
        lead = (lm * vw) / (lm + rm);
        trail = vw - lead;
      end
      xe[0] = vx; xe[1] = vx + lead; xe[2] = vx + vw - trail; xe[3] = vx + vw;
      lead = tm; trail = bm;
      if (tm + bm > vh) begin
        lead = (tm * vh) / (tm + bm);
        trail = vh - lead;
      end
      ye[0] = vy; ye[1] = vy + trail; ye[2] = vy + vh - lead; ye[3] = vy + vh;
      // texture edges use the unscaled margins
      dw = (tex_w == 0) ? 1 : tex_w;
      dh = (tex_h == 0) ? 1 : tex_h;
      ue[0] = clamp_q16(r.tex_u);
      ue[1] = clamp_q16(longint'(r.tex_u) + (lm * 4096) / dw);
      ue[2] = clamp_q16(longint'(r.tex_u) + r.tex_span_u - (rm * 4096) / dw);
      ue[3] = clamp_q16(longint'(r.tex_u) + r.tex_span_u);
      ve[0] = clamp_q16(r.tex_v);
      ve[1] = clamp_q16(longint'(r.tex_v) + (tm * 4096) / dh);
      ve[2] = clamp_q16(longint'(r.tex_v) + r.tex_span_v - (bm * 4096) / dh);
      ve[3] = clamp_q16(longint'(r.tex_v) + r.tex_span_v);
      for (int row = 0; row < NUM_SLICES; row++) begin
        if (ye[3-row] <= ye[2-row]) continue;
        for (int col = 0; col < NUM_SLICES; col++) begin
          if (row == 1 && col == 1 && !fill) continue;
          if (xe[col+1] <= xe[col]) continue;
          q.x = 25'(xe[col]);
          q.y = 25'(ye[2-row]);
          q.w = 20'(xe[col+1] - xe[col]);
          q.h = 20'(ye[3-row] - ye[2-row]);
          q.u = 17'(ue[col]);
          q.v = 17'(ve[row]);
          q.su = 17'(clamp_q16(ue[col+1] - ue[col]));
          q.sv = 17'(clamp_q16(ve[row+1] - ve[row]));
          q.last = 0;
          q.refused = 0;
          found.push_back(q);
        end
      end
      if (found.size() == 0) begin
        push_refusal();
        return;
      end
      found[found.size()-1].last = 1;
      foreach (found[i]) pending_quads.push_back(found[i]);
    endfunction

    function void cmp(string name, longint want, longint got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_quad(quad_t got);
      quad_t want;
      if (pending_quads.size() == 0) begin
        $error("quad transfer with no prediction waiting");
        errors++;
        return;
      end
      want = pending_quads.pop_front();
      cmp("piece_x", want.x, got.x);
      cmp("piece_y", want.y, got.y);
      cmp("piece_width", want.w, got.w);
      cmp("piece_height", want.h, got.h);
      cmp("piece_u", want.u, got.u);
      cmp("piece_v", want.v, got.v);
      cmp("piece_span_u", want.su, got.su);
      cmp("piece_span_v", want.sv, got.sv);
      cmp("last", want.last, got.last);
      cmp("refused", want.refused, got.refused);
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [23:0] view_x, view_y;
  logic [19:0] view_width, view_height;
  logic [16:0] tex_u, tex_v, tex_span_u, tex_span_v;
  logic [19:0] fragment_width, fragment_height;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [24:0] piece_x, piece_y;
  logic [19:0] piece_width, piece_height;
  logic [16:0] piece_u, piece_v, piece_span_u, piece_span_v;
  logic        last;
  logic        refused;

  quad_book book;
  int       send_pct;     // sender idles in this many cycles of a hundred
  int       stall_pct;    // receiver stalls in this many cycles of a hundred
  int       hold_cycles;  // long receiver hold-off, counted down by the receiver

  nine_slice_quad_builder i_dut (
    .clk, .rst,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready,
    .view_x, .view_y, .view_width, .view_height,
    .tex_u, .tex_v, .tex_span_u, .tex_span_v,
    .fragment_width, .fragment_height,
    .out_valid, .out_ready,
    .piece_x, .piece_y, .piece_width, .piece_height,
    .piece_u, .piece_v, .piece_span_u, .piece_span_v,
    .last, .refused
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #3_000_000;
    $display("nine_slice_quad_builder test failed");
    $finish;
  end

  // Receiver: check each quad transfer, then pick next cycle's ready.
  // Values read here are the ones sampled at the edge, before any update.
  always @(posedge clk) begin
    quad_t got;
    if (!rst && out_valid && out_ready) begin
      got.x = piece_x; got.y = piece_y; got.w = piece_width; got.h = piece_height;
      got.u = piece_u; got.v = piece_v; got.su = piece_span_u; got.sv = piece_span_v;
      got.last = last; got.refused = refused;
      book.check_quad(got);
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Write one register; the block must be idle.
  task automatic write_reg(cfg_reg_e idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    book.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one request, with a random idle gap first; note it on transfer.
  task automatic send_req(slice_req_t r);
    if (send_pct > 0 && $urandom_range(99) < send_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_pct) @(posedge clk);
    end
    in_valid        <= 1'b1;
    view_x          <= r.view_x;
    view_y          <= r.view_y;
    view_width      <= r.view_width;
    view_height     <= r.view_height;
    tex_u           <= r.tex_u;
    tex_v           <= r.tex_v;
    tex_span_u      <= r.tex_span_u;
    tex_span_v      <= r.tex_span_v;
    fragment_width  <= r.fragment_width;
    fragment_height <= r.fragment_height;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_req(r);
  endtask

  // Drop valid, drain every predicted quad, then let the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (book.pending_quads.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic slice_req_t make_req(int vx, int vy, int vw, int vh, int tu, int tv,
                                          int su, int sv, int fw, int fh);
    slice_req_t r;
    r.view_x = 24'(vx); r.view_y = 24'(vy); r.view_width = 20'(vw); r.view_height = 20'(vh);
    r.tex_u = 17'(tu); r.tex_v = 17'(tv); r.tex_span_u = 17'(su); r.tex_span_v = 17'(sv);
    r.fragment_width = 20'(fw); r.fragment_height = 20'(fh);
    return r;
  endfunction

  function automatic logic [15:0] rand_margin();
    case ($urandom_range(19))
      0:       return 16'd0;
      1:       return 16'h7fff;
      2:       return 16'($urandom);          // may go negative
      3:       return 16'($urandom) & 16'h7fff;
      default: return 16'($urandom_range(400));
    endcase
  endfunction

  // Mostly well-formed requests whose fragment holds the margins; some noise.
  function automatic slice_req_t rand_req();
    slice_req_t r;
    longint     need_w, need_h;
    r.view_x = 24'($urandom);
    r.view_y = 24'($urandom);
    r.tex_u = 17'($urandom_range(65536));
    r.tex_v = 17'($urandom_range(65536));
    r.tex_span_u = 17'($urandom_range(65536));
    r.tex_span_v = 17'($urandom_range(65536));
    case ($urandom_range(3))
      0: begin
        r.view_width = 20'($urandom_range(200)); r.view_height = 20'($urandom_range(200));
      end
      1: begin
        r.view_width = 20'($urandom); r.view_height = 20'($urandom);
      end
      default: begin
        r.view_width = 20'($urandom_range(8000)); r.view_height = 20'($urandom_range(8000));
      end
    endcase
    if ($urandom_range(4) == 0) begin
      r.tex_u = 17'($urandom); r.tex_v = 17'($urandom);
      r.tex_span_u = 17'($urandom); r.tex_span_v = 17'($urandom);
      r.fragment_width = 20'($urandom);
      r.fragment_height = 20'($urandom);
    end else begin
      need_w = longint'(book.margin_left) + book.margin_right + 1;
      need_h = longint'(book.margin_top) + book.margin_bottom + 1;
      if (need_w < 0) need_w = 0;
      if (need_h < 0) need_h = 0;
      r.fragment_width  = 20'(need_w + $urandom_range(5000));
      r.fragment_height = 20'(need_h + $urandom_range(5000));
    end
    return r;
  endfunction

  initial begin
    rst = 1'b1;
    cfg_valid = 1'b0; cfg_index = CFG_SLICE_TOP; cfg_data = '0;
    in_valid = 1'b0;
    view_x = '0; view_y = '0; view_width = '0; view_height = '0;
    tex_u = '0; tex_v = '0; tex_span_u = '0; tex_span_v = '0;
    fragment_width = '0; fragment_height = '0;
    send_pct = 0; stall_pct = 0; hold_cycles = 0;
    book = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset values: zero margins give just the centre piece.
    send_req(make_req(0, 0, 160, 160, 0, 0, 65536, 65536, 16, 16));
    drain();

    write_reg(CFG_SLICE_TOP, 16'd32);
    write_reg(CFG_SLICE_RIGHT, 16'd48);
    write_reg(CFG_SLICE_BOTTOM, 16'd16);
    write_reg(CFG_SLICE_LEFT, 16'd64);
    write_reg(CFG_TEX_WIDTH, 16'd8);
    write_reg(CFG_TEX_HEIGHT, 16'd16);
    write_reg(CFG_FILL_CENTER, 16'd1);
    send_req(make_req(100, -200, 1600, 800, 1000, 2000, 30000, 40000, 4096, 4096));
    send_req(make_req(5, 5, 50, 800, 0, 0, 65536, 65536, 4096, 4096));       // corners shrink in x
    send_req(make_req(-5, 7, 30, 20, 100, 100, 1000, 1000, 4096, 4096));     // shrink in both axes
    send_req(make_req(0, 0, 0, 0, 0, 0, 65536, 65536, 4096, 4096));          // no quads
    send_req(make_req(0, 0, 1600, 800, 0, 0, 65536, 65536, 112, 4096));      // margins meet width
    send_req(make_req(0, 0, 1600, 800, 0, 0, 65536, 65536, 4096, 48));       // margins meet height
    send_req(make_req(0, 0, 1600, 800, 131071, 131071, 131071, 131071, 4096, 4096)); // past 1.0
    send_req(make_req(-8388608, 8388607, 1048575, 1048575, 0, 65536, 0, 0,
                      1048575, 1048575));
    drain();

    write_reg(CFG_FILL_CENTER, 16'd0);
    send_req(make_req(10, 10, 1600, 800, 500, 500, 60000, 60000, 4096, 4096));
    send_req(make_req(10, 10, 1600, 48, 500, 500, 60000, 60000, 4096, 4096)); // empty middle row
    drain();

    // Extreme margins, zero texture width used as one.
    write_reg(CFG_SLICE_TOP, 16'h7fff);
    write_reg(CFG_SLICE_BOTTOM, 16'd0);
    write_reg(CFG_SLICE_RIGHT, 16'h7fff);
    write_reg(CFG_SLICE_LEFT, 16'd0);
    write_reg(CFG_TEX_WIDTH, 16'd0);
    write_reg(CFG_TEX_HEIGHT, 16'd16384);
    write_reg(CFG_FILL_CENTER, 16'd1);
    send_req(make_req(0, 0, 1048575, 1048575, 0, 0, 65536, 65536, 1048575, 1048575));
    send_req(make_req(0, 0, 1000, 1000, 30000, 30000, 20000, 20000, 1048575, 1048575));
    drain();

    // Negative margin refuses everything.
    write_reg(CFG_SLICE_LEFT, 16'hffff);
    send_req(make_req(0, 0, 1600, 800, 0, 0, 65536, 65536, 4096, 4096));
    send_req(make_req(0, 0, 1600, 800, 0, 0, 65536, 65536, 1048575, 1048575));
    drain();

    // Random phases, cycling through the idling patterns.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_SLICE_TOP, rand_margin());
      write_reg(CFG_SLICE_RIGHT, rand_margin());
      write_reg(CFG_SLICE_BOTTOM, rand_margin());
      write_reg(CFG_SLICE_LEFT, rand_margin());
      write_reg(CFG_FILL_CENTER, 16'($urandom_range(1)));
      write_reg(CFG_TEX_WIDTH, (ph == 3) ? 16'd16384 : 16'($urandom_range(16384)));
      write_reg(CFG_TEX_HEIGHT, (ph == 5) ? 16'd1 : 16'($urandom_range(16384)));
      case (ph % 4)
        0: begin send_pct = 0;  stall_pct = 0;  end
        1: begin send_pct = 60; stall_pct = 0;  end
        2: begin send_pct = 0;  stall_pct = 60; end
        default: begin send_pct = 34; stall_pct = 34; end
      endcase
      repeat (7) send_req(rand_req());
      drain();
    end

    // Back-pressure: hold the receiver off long enough to fill the pipeline.
    write_reg(CFG_SLICE_TOP, 16'd20);
    write_reg(CFG_SLICE_RIGHT, 16'd20);
    write_reg(CFG_SLICE_BOTTOM, 16'd20);
    write_reg(CFG_SLICE_LEFT, 16'd20);
    write_reg(CFG_FILL_CENTER, 16'd1);
    send_pct = 0;
    stall_pct = 0;
    hold_cycles = 300;
    repeat (40) send_req(rand_req());
    drain();

    if (book.pending_quads.size() != 0) begin
      $error("%0d predicted quads never arrived", book.pending_quads.size());
      book.errors++;
    end
    if (book.errors == 0) begin
      $display("nine_slice_quad_builder test passed");
    end else begin
      $display("nine_slice_quad_builder test failed");
    end
    $finish;
  end

endmodule
